### design/ufbd_pkg.sv
// ----------------------------------------------------------------------------
// ufbd_pkg
// Shared widths and constants for the UART fractional baud divider search.
// ----------------------------------------------------------------------------
package ufbd_pkg;

  // Field widths
  localparam int CLOCK_W    = 28;  // peripheral clock in Hz
  localparam int BAUD_W     = 24;  // requested baud
  localparam int FRAC_W     = 4;   // MULVAL / DIVADDVAL
  localparam int DIVISOR_W  = 16;  // divisor latch field (DLM:DLL)
  localparam int ACHIEVED_W = 24;  // achieved baud field

  // 16x oversampling
  localparam int OVS_SHIFT = 4;
  localparam int DEN_W     = BAUD_W + OVS_SHIFT;

  // Divisor register width (default)
  localparam int DIVISOR_BITS_DEFAULT = 16;

  // Reset value of the clock register
  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = CLOCK_W'(60000000);

  // Largest MULVAL
  localparam logic [FRAC_W-1:0] MUL_MAX = 4'd15;

endpackage

### design/ufbd_divider.sv
// ----------------------------------------------------------------------------
// ufbd_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// quotient step and the achieved-baud step of the search.
// ----------------------------------------------------------------------------
module ufbd_divider #(
  parameter int NUM_W = ufbd_pkg::CLOCK_W,
  parameter int DEN_W = ufbd_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] z;      // numerator shifting out, quotient shifting in
  logic [DEN_W-1:0] r;      // partial remainder
  logic [DEN_W-1:0] dv;     // latched divisor
  logic [CNT_W-1:0] cnt;    // bits left
  logic [DEN_W:0]   trial;
  logic             ge;

  // Trial subtraction of one step
  assign trial = {r, z[NUM_W-1]};
  assign ge    = (trial >= {1'b0, dv});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      z  <= num;
      r  <= '0;
      dv <= den;
    end else if (cnt != '0) begin
      z <= {z[NUM_W-2:0], ge};
      if (ge) begin
        r <= DEN_W'(trial - {1'b0, dv});
      end else begin
        r <= trial[DEN_W-1:0];
      end
    end
  end

  assign quot = z;
  assign rem  = r;

endmodule

### design/uart_fractional_baud_divider_search_top.sv
// ----------------------------------------------------------------------------
// uart_fractional_baud_divider_search_top
// Picks divisor, MULVAL and DIVADDVAL for a requested baud with the smallest
// exact relative error, and reports the achieved baud.
// ----------------------------------------------------------------------------
// Search: when the clock is an exact multiple of 16x baud the start point is kept;
//   else each MULVAL/DIVADDVAL pair (0 < DIVADDVAL < MULVAL) of 2 or 3 candidate divisors
//   is tried on the shared 28x21 multiplier. The 28-step serial divider then gives the achieved baud.
// Flow: one item at a time; in_ready is high only while idle, and a finished
//   result waits in the output register without blocking input.
// Reset: clock_hz returns to 60 MHz, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module uart_fractional_baud_divider_search_top #(
  parameter int DIVISOR_BITS = ufbd_pkg::DIVISOR_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [ufbd_pkg::CLOCK_W-1:0]      cfg_wr_data,
  // input item
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ufbd_pkg::BAUD_W-1:0]       requested_baud,
  // result item
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ufbd_pkg::DIVISOR_W-1:0]    divisor,
  output logic [ufbd_pkg::FRAC_W-1:0]       mul_value,
  output logic [ufbd_pkg::FRAC_W-1:0]       add_value,
  output logic [ufbd_pkg::ACHIEVED_W-1:0]   achieved_baud,
  output logic                              divisor_saturated
);

  // Widths
  localparam int CLOCK_W = ufbd_pkg::CLOCK_W;
  localparam int DEN_W   = ufbd_pkg::DEN_W;
  localparam int FRAC_W  = ufbd_pkg::FRAC_W;
  localparam int DB      = DIVISOR_BITS;
  localparam int P_W     = CLOCK_W + 1;          // den * cd
  localparam int N_W     = P_W + 5;              // den * cd * (m + a), error
  localparam int W_W     = DB + 5;               // cd * (m + a)
  localparam int CM_W    = CLOCK_W + FRAC_W;     // clk * m
  localparam int NL_W    = N_W / 2;              // low half of an error
  localparam int MA_W    = DEN_W;                // multiplier operand a
  localparam int MP_W    = MA_W + W_W;           // multiplier product
  localparam int ACC_W   = N_W + W_W;            // cross product
  localparam int DV_W    = (W_W > DEN_W) ? W_W : DEN_W;
  localparam int OVS     = ufbd_pkg::OVS_SHIFT;

  localparam logic [DB-1:0] MAXD = '1;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_INIT2 = 4'd3;
  localparam logic [3:0] S_NEWCD = 4'd4;
  localparam logic [3:0] S_N     = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_ACH   = 4'd9;
  localparam logic [3:0] S_DIV2  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // Partial product phases
  localparam logic [1:0] PH_NL  = 2'd0;
  localparam logic [1:0] PH_NH  = 2'd1;
  localparam logic [1:0] PH_BNL = 2'd2;
  localparam logic [1:0] PH_BNH = 2'd3;

  logic [CLOCK_W-1:0]    clock_hz;
  logic [3:0]            state;

  // Search state
  logic [DEN_W-1:0]      den;
  logic [DB-1:0]         d;         // best divisor
  logic                  sat;
  logic [FRAC_W-1:0]     mul_b;
  logic [FRAC_W-1:0]     add_b;
  logic [N_W-1:0]        best_n;
  logic [W_W-1:0]        best_w;
  logic [CM_W-1:0]       best_cm;
  logic [DB-1:0]         cd;
  logic [DB-1:0]         hi;
  logic [P_W-1:0]        p;
  logic [FRAC_W-1:0]     m;
  logic [FRAC_W-1:0]     a;
  logic [CM_W-1:0]       cm;
  logic [N_W-1:0]        denw;
  logic [N_W-1:0]        denw_m;
  logic [W_W-1:0]        w;
  logic [W_W-1:0]        w_m;
  logic [N_W-1:0]        n;
  logic [1:0]            ph;
  logic [MP_W-1:0]       mul_p;
  logic [ACC_W-1:0]      acc_l;
  logic [ACC_W-1:0]      acc_r;
  logic [ufbd_pkg::ACHIEVED_W-1:0] ach;

  // Shared multiplier operands
  logic [MA_W-1:0]       ma;
  logic [W_W-1:0]        mb;

  // Divider hookup
  logic                  div_start;
  logic [CLOCK_W-1:0]    div_num;
  logic [DV_W-1:0]       div_den;
  logic                  div_done;
  logic [CLOCK_W-1:0]    div_quot;
  logic [DV_W-1:0]       div_rem;

  // Misc combinational
  logic [ufbd_pkg::BAUD_W-1:0] baud_eff;
  logic [DEN_W-1:0]      den_in;
  logic [DB-1:0]         q_sel;
  logic                  q_sat;
  logic [P_W-1:0]        dq;
  logic                  in_acc;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // 16x baud, a zero request counts as 1
  assign baud_eff = (requested_baud == '0) ? ufbd_pkg::BAUD_W'(1) : requested_baud;
  assign den_in   = {baud_eff, {OVS{1'b0}}};

  // Quotient repair: zero becomes one, too large clamps
  always_comb begin
    q_sat = 1'b0;
    if (div_quot == '0) begin
      q_sel = DB'(1);
    end else if (div_quot > CLOCK_W'(MAXD)) begin
      q_sel = MAXD;
      q_sat = 1'b1;
    end else begin
      q_sel = div_quot[DB-1:0];
    end
  end

  assign dq = mul_p[P_W-1:0];

  // Divider input select
  assign div_start = in_acc || (state == S_ACH);
  assign div_num   = (state == S_ACH) ? best_cm[CM_W-1:OVS] : clock_hz;
  assign div_den   = (state == S_ACH) ? DV_W'(best_w) : DV_W'(den_in);

  ufbd_divider #(
    .NUM_W (CLOCK_W),
    .DEN_W (DV_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_INIT: begin
        ma = den;
        mb = W_W'(d);
      end
      S_MUL: begin
        case (ph)
          PH_NL: begin
            ma = MA_W'(n[NL_W-1:0]);
            mb = best_w;
          end
          PH_NH: begin
            ma = MA_W'(n[N_W-1:NL_W]);
            mb = best_w;
          end
          PH_BNL: begin
            ma = MA_W'(best_n[NL_W-1:0]);
            mb = w;
          end
          PH_BNH: begin
            ma = MA_W'(best_n[N_W-1:NL_W]);
            mb = w;
          end
          default: begin
            ma = '0;
            mb = '0;
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Registered product
  always_ff @(posedge clk) begin
    mul_p <= MP_W'(ma) * MP_W'(mb);
  end

  // Clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= ufbd_pkg::CLOCK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clock_hz <= cfg_wr_data;
    end
  end

  // Sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            state <= (div_rem != '0) ? S_INIT : S_ACH;
          end
        end
        S_INIT:  state <= S_INIT2;
        S_INIT2: state <= S_NEWCD;
        S_NEWCD: state <= S_N;
        S_N:     state <= S_MUL;
        S_MUL: begin
          if (ph == PH_BNH) begin
            state <= S_ACC;
          end
        end
        S_ACC:   state <= S_CMP;
        S_CMP: begin
          if (a < m - 1'b1 || m < ufbd_pkg::MUL_MAX) begin
            state <= S_N;
          end else if (cd != hi) begin
            state <= S_NEWCD;
          end else begin
            state <= S_ACH;
          end
        end
        S_ACH:   state <= S_DIV2;
        S_DIV2: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          den <= den_in;
        end
      end
      S_DIV1: begin
        // start point: D = q, fraction 0/1
        if (div_done) begin
          d       <= q_sel;
          sat     <= q_sat;
          best_w  <= W_W'(q_sel);
          best_cm <= CM_W'(clock_hz);
          mul_b   <= FRAC_W'(1);
          add_b   <= '0;
        end
      end
      S_INIT2: begin
        // error of the start point and the divisor range
        if (dq >= P_W'(clock_hz)) begin
          best_n <= N_W'(dq - P_W'(clock_hz));
        end else begin
          best_n <= N_W'(P_W'(clock_hz) - dq);
        end
        if (d > DB'(1)) begin
          cd <= d - 1'b1;
          p  <= dq - P_W'(den);
        end else begin
          cd <= DB'(1);
          p  <= dq;
        end
        hi <= (d != MAXD) ? d + 1'b1 : MAXD;
      end
      S_NEWCD: begin
        // first candidate of a divisor: m = 2, a = 1, weight 3
        denw   <= N_W'(p) + (N_W'(p) << 1);
        denw_m <= N_W'(p) + (N_W'(p) << 1);
        w      <= W_W'(cd) + (W_W'(cd) << 1);
        w_m    <= W_W'(cd) + (W_W'(cd) << 1);
        m      <= FRAC_W'(2);
        a      <= FRAC_W'(1);
        cm     <= CM_W'(clock_hz) << 1;
      end
      S_N: begin
        if (denw >= N_W'(cm)) begin
          n <= denw - N_W'(cm);
        end else begin
          n <= N_W'(cm) - denw;
        end
        ph <= PH_NL;
      end
      S_MUL: begin
        ph <= ph + 1'b1;
        case (ph)
          PH_NH:   acc_l <= ACC_W'(mul_p);
          PH_BNL:  acc_l <= acc_l + (ACC_W'(mul_p) << NL_W);
          PH_BNH:  acc_r <= ACC_W'(mul_p);
          default: acc_r <= acc_r;
        endcase
      end
      S_ACC: begin
        acc_r <= acc_r + (ACC_W'(mul_p) << NL_W);
      end
      S_CMP: begin
        // keep strictly better candidate
        if (acc_l < acc_r) begin
          best_n  <= n;
          best_w  <= w;
          best_cm <= cm;
          d       <= cd;
          mul_b   <= m;
          add_b   <= a;
        end
        // step to next candidate
        if (a < m - 1'b1) begin
          a    <= a + 1'b1;
          denw <= denw + N_W'(p);
          w    <= w + W_W'(cd);
        end else if (m < ufbd_pkg::MUL_MAX) begin
          m      <= m + 1'b1;
          a      <= FRAC_W'(1);
          cm     <= cm + CM_W'(clock_hz);
          denw   <= denw_m + N_W'(p);
          denw_m <= denw_m + N_W'(p);
          w      <= w_m + W_W'(cd);
          w_m    <= w_m + W_W'(cd);
        end else if (cd != hi) begin
          cd <= cd + 1'b1;
          p  <= p + P_W'(den);
        end
      end
      S_DIV2: begin
        if (div_done) begin
          ach <= div_quot[ufbd_pkg::ACHIEVED_W-1:0];
        end
      end
      default: begin
        ph <= ph;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      divisor           <= ufbd_pkg::DIVISOR_W'(d);
      mul_value         <= mul_b;
      add_value         <= add_b;
      achieved_baud     <= ach;
      divisor_saturated <= sat;
    end
  end

endmodule
